### hdl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Concurrent checks clocked on clk and disabled while arst_n is low.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define SKJ_ASSERT(lbl, prop) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) \
		else $error("assertion failed");
`define SKJ_NEVER(lbl, expr) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) !(expr)) \
		else $error("forbidden condition seen");
`else
`define SKJ_ASSERT(lbl, prop)
`define SKJ_NEVER(lbl, expr)
`endif
`endif

### hdl/skj_pkg.sv
// ----------------------------------------------------------------------------
// Skinning joint matrix package
// Word types, command codes and fixed-point helpers.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package skj_pkg;

	localparam int JOINTS_DEF = 26;
	localparam int HANDS_DEF  = 2;
	localparam int CW         = 23;

	localparam logic [1:0]         ROW_LAST = 2'd2;
	localparam logic signed [31:0] ONE_Q16  = 32'sd65536;
	localparam logic signed [34:0] ONE_Q28  = 35'sd268435456;

	typedef enum logic [1:0] {
		CMD_BIND    = 2'd0,
		CMD_WRIST   = 2'd1,
		CMD_COMPUTE = 2'd2,
		CMD_NONE    = 2'd3
	} cmd_t;

	typedef struct packed {
		cmd_t               command;
		logic               hand;
		logic [4:0]         joint_index;
		logic signed [15:0] quat_w;
		logic signed [15:0] quat_x;
		logic signed [15:0] quat_y;
		logic signed [15:0] quat_z;
		logic signed [23:0] pos_x;
		logic signed [23:0] pos_y;
		logic signed [23:0] pos_z;
	} pose_t;

	typedef struct packed {
		logic               out_hand;
		logic [4:0]         out_joint;
		logic [1:0]         row_index;
		logic signed [31:0] col0;
		logic signed [31:0] col1;
		logic signed [31:0] col2;
		logic signed [31:0] col3;
		logic               last_row;
	} mrow_t;

	typedef struct packed {
		pose_t      p;
		logic [1:0] row;
	} beat_t;

	typedef logic [11:0][31:0] mat12_t;

	function automatic mat12_t ident_mat();
		mat12_t m;
		m     = '0;
		m[0]  = ONE_Q16;
		m[5]  = ONE_Q16;
		m[10] = ONE_Q16;
		return m;
	endfunction

	function automatic logic signed [67:0] rnd16(input logic signed [67:0] v);
		return (v + 68'sd32768) >>> 16;
	endfunction

	function automatic logic signed [31:0] sat32(input logic signed [67:0] v);
		if (v > 68'sd2147483647) begin
			return 32'sh7fffffff;
		end else if (v < -68'sd2147483648) begin
			return 32'sh80000000;
		end
		return v[31:0];
	endfunction

endpackage

### hdl/skj_chan_if.sv
// ----------------------------------------------------------------------------
// Skinning channel interface
// Valid/ready channel carrying one word of type T.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface skj_chan_if #(parameter type T = logic) ();
	logic valid;
	logic ready;
	T     data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

### hdl/skinning_joint_matrix.sv
// ----------------------------------------------------------------------------
// Skinning joint matrix
// Pose words in, rows of wrist_inverse * pose * bind_inverse out.
// ----------------------------------------------------------------------------
// Channel pose takes one pose word per handshake: a bind load or a wrist load
// stores the rigid inverse of the pose, a compute word gives three row words.
// Channel mat gives one row word per handshake, last_row set on row two.
// Load words and dropped words (unknown command, hand out of range, or joint
// out of range on a bind or compute word) are taken on their handshake; a
// compute word enters the stages once per row, pose.ready low until its last
// row is in, as the row multiplier banks of both products are shared by rows.
// Rows pass s1 to s8 and out_q, and follow back to back while mat is ready.
// Stages move forward whenever the next one is empty or moving, so pose words
// keep being taken while a row waits on mat; when mat stalls, words pile up
// in the stages until the entry stage is full, then pose.ready falls.
// Reset empties the stages and sets every wrist inverse to identity. The bind
// table has no reset: a compute word must follow the bind load of its joint.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module skinning_joint_matrix
	import skj_pkg::*;
#(
	parameter int JOINTS = JOINTS_DEF,
	parameter int HANDS  = HANDS_DEF
) (
	input logic         clk,
	input logic         arst_n,
	skj_chan_if.sink    pose,
	skj_chan_if.source  mat
);

	localparam int SLOTS = HANDS * JOINTS;
	localparam int AW    = (SLOTS > 1) ? $clog2(SLOTS) : 1;

	logic   busy_q;
	logic [1:0] beat_q;
	pose_t  item_q;
	logic   keep;

	logic adv1, adv2, adv3, adv4, adv5, adv6, adv7, adv8, adv_o;

	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7, v_s8, out_v_q;
	beat_t b_s1, b_s2, b_s3, b_s4, b_s5, b_s6, b_s7, b_s8;
	mrow_t out_q;

	logic signed [31:0]   p_s2 [9];
	logic signed [34:0]   r3 [9];
	logic signed [CW-1:0] c3_d [9];
	logic signed [CW-1:0] c_s3 [9];
	logic signed [23:0]   tv3 [3];
	logic signed [46:0]   ip_d [9];
	logic signed [46:0]   ip_s4 [9];
	logic signed [CW-1:0] c_s4 [9];
	mat12_t               inv_d;
	logic [AW-1:0]        addr4;
	logic                 we_bind, we_wrist;

	mat12_t               bind_mem [SLOTS];
	mat12_t               wi_q [HANDS];

	logic signed [CW-1:0] c_s5 [9];
	mat12_t               bi_s5;
	mat12_t               wsel;
	logic signed [23:0]   cm [12];
	logic signed [55:0]   tp_d [12];
	logic signed [31:0]   wi3_d;
	logic signed [55:0]   tp_s6 [12];
	logic signed [31:0]   wi3_s6;
	mat12_t               bi_s6;
	logic signed [67:0]   acc7 [4];
	logic signed [31:0]   t_d [4];
	logic signed [31:0]   t_s7 [4];
	mat12_t               bi_s7;
	logic signed [63:0]   rp_d [12];
	logic signed [63:0]   rp_s8 [12];
	logic signed [31:0]   t3_s8;
	logic signed [67:0]   acc8 [4];
	logic signed [31:0]   col_d [4];

	// Stage flow
	always_comb begin
		adv_o = !out_v_q || mat.ready;
		adv8  = !v_s8 || adv_o;
		adv7  = !v_s7 || adv8;
		adv6  = !v_s6 || adv7;
		adv5  = !v_s5 || adv6;
		adv4  = !v_s4 || adv5;
		adv3  = !v_s3 || adv4;
		adv2  = !v_s2 || adv3;
		adv1  = !v_s1 || adv2;
	end

	assign pose.ready = adv1 && !busy_q;
	assign mat.valid  = out_v_q;
	assign mat.data   = out_q;

	always_comb begin
		keep = pose.valid && (pose.data.command != CMD_NONE)
			&& (int'(pose.data.hand) < HANDS)
			&& ((pose.data.command == CMD_WRIST) || (int'(pose.data.joint_index) < JOINTS));
	end

	// Rotation and inverse arithmetic
	always_comb begin
		r3[0] = ONE_Q28 - ((35'(p_s2[1]) + 35'(p_s2[2])) <<< 1);
		r3[1] = (35'(p_s2[3]) - 35'(p_s2[4])) <<< 1;
		r3[2] = (35'(p_s2[5]) + 35'(p_s2[6])) <<< 1;
		r3[3] = (35'(p_s2[3]) + 35'(p_s2[4])) <<< 1;
		r3[4] = ONE_Q28 - ((35'(p_s2[0]) + 35'(p_s2[2])) <<< 1);
		r3[5] = (35'(p_s2[7]) - 35'(p_s2[8])) <<< 1;
		r3[6] = (35'(p_s2[5]) - 35'(p_s2[6])) <<< 1;
		r3[7] = (35'(p_s2[7]) + 35'(p_s2[8])) <<< 1;
		r3[8] = ONE_Q28 - ((35'(p_s2[0]) + 35'(p_s2[1])) <<< 1);
		for (int i = 0; i < 9; i++) begin
			c3_d[i] = CW'((r3[i] + 35'sd2048) >>> 12);
		end

		tv3[0] = b_s3.p.pos_x;
		tv3[1] = b_s3.p.pos_y;
		tv3[2] = b_s3.p.pos_z;
		for (int r = 0; r < 3; r++) begin
			for (int c = 0; c < 3; c++) begin
				ip_d[r*3+c] = 47'(c_s3[c*3+r]) * 47'(tv3[c]);
			end
		end

		for (int r = 0; r < 3; r++) begin
			for (int c = 0; c < 3; c++) begin
				inv_d[r*4+c] = 32'(c_s4[c*3+r]);
			end
			inv_d[r*4+3] = sat32(-rnd16(68'(ip_s4[r*3]) + 68'(ip_s4[r*3+1])
				+ 68'(ip_s4[r*3+2])));
		end

		addr4    = AW'(int'(b_s4.p.hand) * JOINTS + int'(b_s4.p.joint_index));
		we_bind  = v_s4 && adv5 && (b_s4.p.command == CMD_BIND);
		we_wrist = v_s4 && adv5 && (b_s4.p.command == CMD_WRIST);
	end

	// Row products
	always_comb begin
		wsel = wi_q[b_s5.p.hand];
		for (int k = 0; k < 3; k++) begin
			for (int j = 0; j < 3; j++) begin
				cm[k*4+j] = 24'(c_s5[k*3+j]);
			end
		end
		cm[3]  = b_s5.p.pos_x;
		cm[7]  = b_s5.p.pos_y;
		cm[11] = b_s5.p.pos_z;
		for (int k = 0; k < 3; k++) begin
			for (int j = 0; j < 4; j++) begin
				tp_d[k*4+j] = 56'($signed(wsel[int'(b_s5.row)*4+k])) * 56'(cm[k*4+j]);
			end
		end
		wi3_d = $signed(wsel[int'(b_s5.row)*4+3]);

		for (int j = 0; j < 4; j++) begin
			acc7[j] = 68'(tp_s6[j]) + 68'(tp_s6[4+j]) + 68'(tp_s6[8+j]);
			if (j == 3) begin
				acc7[j] = acc7[j] + (68'(wi3_s6) <<< 16);
			end
			t_d[j] = sat32(rnd16(acc7[j]));
		end

		for (int k = 0; k < 3; k++) begin
			for (int j = 0; j < 4; j++) begin
				rp_d[k*4+j] = 64'(t_s7[k]) * 64'($signed(bi_s7[k*4+j]));
			end
		end

		for (int j = 0; j < 4; j++) begin
			acc8[j] = 68'(rp_s8[j]) + 68'(rp_s8[4+j]) + 68'(rp_s8[8+j]);
			if (j == 3) begin
				acc8[j] = acc8[j] + (68'(t3_s8) <<< 16);
			end
			col_d[j] = sat32(rnd16(acc8[j]));
		end
	end

	// Control, valid bits and wrist inverses
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q  <= 1'b0;
			beat_q  <= 2'd0;
			v_s1    <= 1'b0;
			v_s2    <= 1'b0;
			v_s3    <= 1'b0;
			v_s4    <= 1'b0;
			v_s5    <= 1'b0;
			v_s6    <= 1'b0;
			v_s7    <= 1'b0;
			v_s8    <= 1'b0;
			out_v_q <= 1'b0;
			for (int h = 0; h < HANDS; h++) begin
				wi_q[h] <= ident_mat();
			end
		end else begin
			if (adv1) begin
				if (busy_q) begin
					v_s1   <= 1'b1;
					beat_q <= beat_q + 2'd1;
					if (beat_q == ROW_LAST) begin
						busy_q <= 1'b0;
					end
				end else begin
					v_s1 <= keep;
					if (keep && (pose.data.command == CMD_COMPUTE)) begin
						busy_q <= 1'b1;
						beat_q <= 2'd1;
					end
				end
			end
			if (adv2) begin
				v_s2 <= v_s1;
			end
			if (adv3) begin
				v_s3 <= v_s2;
			end
			if (adv4) begin
				v_s4 <= v_s3;
			end
			if (adv5) begin
				v_s5 <= v_s4 && (b_s4.p.command == CMD_COMPUTE);
			end
			if (adv6) begin
				v_s6 <= v_s5;
			end
			if (adv7) begin
				v_s7 <= v_s6;
			end
			if (adv8) begin
				v_s8 <= v_s7;
			end
			if (adv_o) begin
				out_v_q <= v_s8;
			end
			if (we_wrist) begin
				wi_q[b_s4.p.hand] <= inv_d;
			end
		end
	end

	// Bind inverse table
	always_ff @(posedge clk) begin
		if (we_bind) begin
			bind_mem[addr4] <= inv_d;
		end
		if (adv5) begin
			bi_s5 <= bind_mem[addr4];
		end
	end

	// Stage words
	always_ff @(posedge clk) begin
		if (adv1) begin
			if (busy_q) begin
				b_s1 <= '{p: item_q, row: beat_q};
			end else begin
				b_s1   <= '{p: pose.data, row: 2'd0};
				item_q <= pose.data;
			end
		end
		if (adv2) begin
			b_s2    <= b_s1;
			p_s2[0] <= 32'(b_s1.p.quat_x) * 32'(b_s1.p.quat_x);
			p_s2[1] <= 32'(b_s1.p.quat_y) * 32'(b_s1.p.quat_y);
			p_s2[2] <= 32'(b_s1.p.quat_z) * 32'(b_s1.p.quat_z);
			p_s2[3] <= 32'(b_s1.p.quat_x) * 32'(b_s1.p.quat_y);
			p_s2[4] <= 32'(b_s1.p.quat_w) * 32'(b_s1.p.quat_z);
			p_s2[5] <= 32'(b_s1.p.quat_x) * 32'(b_s1.p.quat_z);
			p_s2[6] <= 32'(b_s1.p.quat_w) * 32'(b_s1.p.quat_y);
			p_s2[7] <= 32'(b_s1.p.quat_y) * 32'(b_s1.p.quat_z);
			p_s2[8] <= 32'(b_s1.p.quat_w) * 32'(b_s1.p.quat_x);
		end
		if (adv3) begin
			b_s3 <= b_s2;
			c_s3 <= c3_d;
		end
		if (adv4) begin
			b_s4  <= b_s3;
			c_s4  <= c_s3;
			ip_s4 <= ip_d;
		end
		if (adv5) begin
			b_s5 <= b_s4;
			c_s5 <= c_s4;
		end
		if (adv6) begin
			b_s6   <= b_s5;
			tp_s6  <= tp_d;
			wi3_s6 <= wi3_d;
			bi_s6  <= bi_s5;
		end
		if (adv7) begin
			b_s7  <= b_s6;
			t_s7  <= t_d;
			bi_s7 <= bi_s6;
		end
		if (adv8) begin
			b_s8  <= b_s7;
			rp_s8 <= rp_d;
			t3_s8 <= t_s7[3];
		end
		if (adv_o) begin
			out_q.out_hand  <= b_s8.p.hand;
			out_q.out_joint <= b_s8.p.joint_index;
			out_q.row_index <= b_s8.row;
			out_q.col0      <= col_d[0];
			out_q.col1      <= col_d[1];
			out_q.col2      <= col_d[2];
			out_q.col3      <= col_d[3];
			out_q.last_row  <= (b_s8.row == ROW_LAST);
		end
	end

	`SKJ_ASSERT(a_busy_beat, busy_q |-> (beat_q == 2'd1 || beat_q == ROW_LAST))
	`SKJ_ASSERT(a_rows_compute, v_s8 |-> (b_s8.p.command == CMD_COMPUTE))
	`SKJ_ASSERT(a_last_row, out_v_q |-> (out_q.last_row == (out_q.row_index == ROW_LAST)))
	`SKJ_NEVER(a_ready_busy, pose.ready && busy_q)

endmodule

### tb/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Skinning joint matrix testbench
// Drives bind, wrist and compute pose words with random gaps on both channels,
// predicts wrist_inverse * pose * bind_inverse per compute word and checks
// every row word field by field against the oldest prediction.
// ----------------------------------------------------------------------------

module testbench;
	import skj_pkg::*;

	typedef longint aff_t [12];

	typedef struct {
		pose_t p;
		bit    typed_ident;
	} step_t;

	localparam int WATCHDOG_LIMIT = 2000;
	localparam int N_RANDOM       = 220;

	logic clk;
	logic arst_n;

	skj_chan_if #(.T(pose_t)) pose ();
	skj_chan_if #(.T(mrow_t)) mat ();

	skinning_joint_matrix i_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.pose   (pose),
		.mat    (mat)
	);

	longint bind_inv [2][26][12];
	longint wrist_inv [2][12];
	bit     bound [2][32];
	mrow_t  rows_due [$];
	bit     failed;
	bit     calm;
	int     idle_cycles;
	step_t  steps [$];

	initial begin
		clk = 1'b0;
		forever begin
			#5 clk = ~clk;
		end
	end

	function automatic longint rnd_shr(longint v, int s);
		return (v + (longint'(1) << (s - 1))) >>> s;
	endfunction

	function automatic longint clip32(longint v);
		if (v > 64'sd2147483647) begin
			return 64'sd2147483647;
		end else if (v < -64'sd2147483648) begin
			return -64'sd2147483648;
		end
		return v;
	endfunction

	function automatic void pose_to_affine(pose_t p, output aff_t m);
		longint w, x, y, z, one;
		longint r [9];
		w   = longint'(p.quat_w);
		x   = longint'(p.quat_x);
		y   = longint'(p.quat_y);
		z   = longint'(p.quat_z);
		one = longint'(1) << 28;
		r[0] = one - 2 * (y * y + z * z);
		r[1] = 2 * (x * y - w * z);
		r[2] = 2 * (x * z + w * y);
		r[3] = 2 * (x * y + w * z);
		r[4] = one - 2 * (x * x + z * z);
		r[5] = 2 * (y * z - w * x);
		r[6] = 2 * (x * z - w * y);
		r[7] = 2 * (y * z + w * x);
		r[8] = one - 2 * (x * x + y * y);
		for (int i = 0; i < 3; i++) begin
			for (int c = 0; c < 3; c++) begin
				m[i * 4 + c] = rnd_shr(r[i * 3 + c], 12);
			end
		end
		m[3]  = longint'(p.pos_x);
		m[7]  = longint'(p.pos_y);
		m[11] = longint'(p.pos_z);
	endfunction

	function automatic void invert_rigid(aff_t m, output aff_t d);
		longint acc;
		for (int r = 0; r < 3; r++) begin
			acc = 0;
			for (int c = 0; c < 3; c++) begin
				d[r * 4 + c] = clip32(m[c * 4 + r]);
				acc += m[c * 4 + r] * m[c * 4 + 3];
			end
			d[r * 4 + 3] = clip32(-rnd_shr(acc, 16));
		end
	endfunction

	function automatic void compose(aff_t a, aff_t b, output aff_t c);
		longint acc;
		for (int r = 0; r < 3; r++) begin
			for (int j = 0; j < 4; j++) begin
				acc = (j == 3) ? a[r * 4 + 3] * 65536 : 0;
				for (int k = 0; k < 3; k++) begin
					acc += a[r * 4 + k] * b[k * 4 + j];
				end
				c[r * 4 + j] = clip32(rnd_shr(acc, 16));
			end
		end
	endfunction

	function automatic void queue_rows(logic h, logic [4:0] j, aff_t m);
		mrow_t w;
		for (int r = 0; r < 3; r++) begin
			w.out_hand  = h;
			w.out_joint = j;
			w.row_index = r[1:0];
			w.col0      = m[r * 4 + 0][31:0];
			w.col1      = m[r * 4 + 1][31:0];
			w.col2      = m[r * 4 + 2][31:0];
			w.col3      = m[r * 4 + 3][31:0];
			w.last_row  = (r[1:0] == ROW_LAST);
			rows_due.push_back(w);
		end
	endfunction

	// advance the predicted state by one accepted pose word
	function automatic void predict_pose(step_t s);
		aff_t pm, inv, wi, bi, tmp, res, ident;
		pose_t p;
		p = s.p;
		if (p.command == CMD_NONE) begin
			return;
		end
		pose_to_affine(p, pm);
		if (p.command == CMD_WRIST) begin
			invert_rigid(pm, inv);
			wrist_inv[p.hand] = inv;
			return;
		end
		if (p.joint_index >= 26) begin
			return;
		end
		if (p.command == CMD_BIND) begin
			invert_rigid(pm, inv);
			bind_inv[p.hand][p.joint_index] = inv;
			return;
		end
		if (s.typed_ident) begin
			ident = '{65536, 0, 0, 0, 0, 65536, 0, 0, 0, 0, 65536, 0};
			queue_rows(p.hand, p.joint_index, ident);
			return;
		end
		wi = wrist_inv[p.hand];
		bi = bind_inv[p.hand][p.joint_index];
		compose(wi, pm, tmp);
		compose(tmp, bi, res);
		queue_rows(p.hand, p.joint_index, res);
	endfunction

	function automatic pose_t mk(cmd_t c, logic h, logic [4:0] j, int w, int x, int y, int z,
			int px, int py, int pz);
		pose_t p;
		p.command     = c;
		p.hand        = h;
		p.joint_index = j;
		p.quat_w      = w[15:0];
		p.quat_x      = x[15:0];
		p.quat_y      = y[15:0];
		p.quat_z      = z[15:0];
		p.pos_x       = px[23:0];
		p.pos_y       = py[23:0];
		p.pos_z       = pz[23:0];
		return p;
	endfunction

	function automatic int rq();
		return int'($urandom_range(32768)) - 16384;
	endfunction

	function automatic int rpos();
		return int'($urandom_range(16777215)) - 8388608;
	endfunction

	function automatic step_t random_step();
		step_t s;
		cmd_t c;
		int sel;
		logic h;
		logic [4:0] j;
		sel = $urandom_range(99);
		h   = 1'($urandom_range(1));
		j   = (sel % 10 == 0) ? 5'($urandom_range(31)) : 5'($urandom_range(25));
		if (sel < 5) begin
			c = CMD_NONE;
		end else if (sel < 25) begin
			c = CMD_WRIST;
		end else if (sel < 50) begin
			c = CMD_BIND;
		end else begin
			c = CMD_COMPUTE;
		end
		if (c == CMD_COMPUTE && !bound[h][j]) begin
			c = CMD_BIND;
		end
		if (c == CMD_BIND && j < 26) begin
			bound[h][j] = 1'b1;
		end
		s.p = mk(c, h, j, rq(), rq(), rq(), rq(), rpos(), rpos(), rpos());
		s.typed_ident = 1'b0;
		return s;
	endfunction

	function automatic void add(pose_t p, bit t);
		step_t s;
		s.p = p;
		s.typed_ident = t;
		steps.push_back(s);
	endfunction

	function automatic int draw_gap();
		return calm ? 0 : int'($urandom_range(17));
	endfunction

	// pose side
	initial begin
		int gap;
		pose.valid  = 1'b0;
		pose.data   = '0;
		arst_n      = 1'b0;
		calm        = 1'b0;
		for (int h = 0; h < 2; h++) begin
			wrist_inv[h] = '{65536, 0, 0, 0, 0, 65536, 0, 0, 0, 0, 65536, 0};
		end
		add(mk(CMD_BIND, 0, 0, 16384, 0, 0, 0, 0, 0, 0), 0);
		add(mk(CMD_COMPUTE, 0, 0, 16384, 0, 0, 0, 0, 0, 0), 1);
		add(mk(CMD_BIND, 1, 25, 16384, 0, 0, 0, 8388607, 8388607, 8388607), 0);
		add(mk(CMD_COMPUTE, 1, 25, 16384, 0, 0, 0, 8388607, 8388607, 8388607), 1);
		add(mk(CMD_COMPUTE, 1, 25, 16384, 0, 0, 0, -8388608, -8388608, -8388608), 0);
		add(mk(CMD_NONE, 0, 0, 16384, 0, 0, 0, 0, 0, 0), 0);
		add(mk(CMD_BIND, 0, 26, -16384, 16384, 0, 0, 5, 5, 5), 0);
		add(mk(CMD_COMPUTE, 0, 31, 16384, 0, 0, 0, 0, 0, 0), 0);
		add(mk(CMD_WRIST, 0, 31, -16384, -16384, -16384, -16384, -8388608, -8388608,
			-8388608), 0);
		add(mk(CMD_BIND, 0, 1, 16384, 16384, 16384, 16384, 8388607, 8388607, 8388607), 0);
		add(mk(CMD_COMPUTE, 0, 1, 16384, -16384, 16384, -16384, 8388607, -8388608, 0), 0);
		add(mk(CMD_COMPUTE, 0, 0, -16384, 0, 0, 0, -8388608, 8388607, -1), 0);
		add(mk(CMD_WRIST, 1, 0, 0, 0, 0, 0, 0, 0, 0), 0);
		add(mk(CMD_COMPUTE, 1, 25, -16384, 16384, -16384, 16384, 1, -1, 8388607), 0);
		add(mk(CMD_BIND, 1, 3, 0, 16384, 0, 0, 65536, -65536, 0), 0);
		add(mk(CMD_COMPUTE, 1, 3, 11585, 0, 11585, 0, 100000, 0, -100000), 0);
		add(mk(CMD_WRIST, 0, 0, 16384, 0, 0, 0, 0, 0, 0), 0);
		add(mk(CMD_COMPUTE, 0, 0, 16384, 0, 0, 0, 0, 0, 0), 1);
		bound[0][0]  = 1'b1;
		bound[0][1]  = 1'b1;
		bound[1][3]  = 1'b1;
		bound[1][25] = 1'b1;
		for (int i = 0; i < N_RANDOM; i++) begin
			steps.push_back(random_step());
		end
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		gap = draw_gap();
		foreach (steps[i]) begin
			if (i > 18 && (i % 40) == 0) begin
				calm = ~calm;
			end
			if (gap > 0) begin
				repeat (gap) @(posedge clk);
			end
			pose.valid <= 1'b1;
			pose.data  <= steps[i].p;
			do begin
				@(posedge clk);
			end while (!pose.ready);
			predict_pose(steps[i]);
			gap = draw_gap();
			if (gap > 0 || i == steps.size() - 1) begin
				pose.valid <= 1'b0;
			end
		end
		while (rows_due.size() > 0) begin
			@(posedge clk);
		end
		repeat (20) @(posedge clk);
		if (!failed) begin
			$display("testbench OK");
		end else begin
			$display("testbench NOT OK");
		end
		$finish;
	end

	// mat side
	initial begin
		int n;
		mat.ready = 1'b0;
		@(posedge arst_n);
		forever begin
			n = draw_gap();
			if (n > 0) begin
				mat.ready <= 1'b0;
				repeat (n) @(posedge clk);
			end
			mat.ready <= 1'b1;
			do begin
				@(posedge clk);
			end while (!(mat.valid && mat.ready));
		end
	end

	always @(posedge clk) begin
		mrow_t e;
		mrow_t a;
		if (arst_n && mat.valid && mat.ready) begin
			a = mat.data;
			if (rows_due.size() == 0) begin
				$display("%0t: row word with none due: %p", $time, a);
				failed <= 1'b1;
			end else begin
				e = rows_due.pop_front();
				if (a.out_hand !== e.out_hand || a.out_joint !== e.out_joint
						|| a.row_index !== e.row_index || a.last_row !== e.last_row
						|| a.col0 !== e.col0 || a.col1 !== e.col1
						|| a.col2 !== e.col2 || a.col3 !== e.col3) begin
					$display("%0t: row mismatch expected %p actual %p", $time, e, a);
					failed <= 1'b1;
				end
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (pose.valid && pose.ready) || (mat.valid && mat.ready)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("testbench NOT OK");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

endmodule
